[rtl/akv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// akv_pkg
// Shared types, sizes and helpers for the associative key/value table.
// ----------------------------------------------------------------------------
package akv_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_BYTES = 8;

    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_GET   = 2'd1,
        OP_DEL   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Search item that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             hit;
        logic [VAL_W-1:0] hit_value;
        logic             free_seen;
        logic [IDX_W-1:0] free_idx;
    } t_token;

    // Broadcast commands from the controller to every cell.
    typedef struct packed {
        logic             clear;
        logic             fill;
        logic [IDX_W-1:0] fill_idx;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

    // Keep bytes up to the first zero byte, at most nbytes of them.
    function automatic logic [63:0] trim_word(input logic [63:0] word,
                                              input int unsigned nbytes);
        logic        alive;
        logic [63:0] kept;
        alive = 1'b1;
        kept  = '0;
        for (int i = 0; i < 8; i++) begin
            if (i >= nbytes || word[8*i +: 8] == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                kept[8*i +: 8] = word[8*i +: 8];
            end
        end
        return kept;
    endfunction

    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] word);
        return trim_word(word, KEY_BYTES);
    endfunction

    function automatic logic [VAL_W-1:0] trim_value(input logic [VAL_W-1:0] word);
        return trim_word(word, VALUE_BYTES);
    endfunction

endpackage
`default_nettype wire

[rtl/akv_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// akv_cell
// One table slot: valid mark, key and value; checks the passing search item.
// ----------------------------------------------------------------------------
module akv_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [akv_pkg::IDX_W-1:0] i_idx,
    input  wire akv_pkg::t_cell_ctl        i_ctl,
    input  wire akv_pkg::t_token           i_tok,
    output akv_pkg::t_token                o_tok
);

    logic                      r_valid;
    logic                      n_valid;
    logic [akv_pkg::KEY_W-1:0] r_key;
    logic [akv_pkg::KEY_W-1:0] n_key;
    logic [akv_pkg::VAL_W-1:0] r_value;
    logic [akv_pkg::VAL_W-1:0] n_value;
    akv_pkg::t_token           r_tok;
    akv_pkg::t_token           n_tok;
    logic                      w_match;
    logic                      w_take_free;
    logic                      w_fill_me;

    always_comb begin
        w_match     = i_tok.valid && r_valid && !i_tok.hit && (r_key == i_tok.key);
        w_take_free = i_tok.valid && !r_valid && !i_tok.free_seen;
        w_fill_me   = i_ctl.fill && (i_ctl.fill_idx == i_idx);

        // pass the item on, marking first hit and first free slot
        n_tok = i_tok;
        if (w_match) begin
            n_tok.hit       = 1'b1;
            n_tok.hit_value = r_value;
        end
        if (w_take_free) begin
            n_tok.free_seen = 1'b1;
            n_tok.free_idx  = i_idx;
        end

        n_valid = r_valid;
        n_key   = r_key;
        n_value = r_value;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (w_fill_me) begin
            n_valid = 1'b1;
            n_key   = i_ctl.key;
            n_value = i_ctl.value;
        end else if (w_match && i_tok.op == akv_pkg::OP_SET) begin
            n_value = i_tok.value;
        end else if (w_match && i_tok.op == akv_pkg::OP_DEL) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

[rtl/associative_key_value_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// associative_key_value_table_core
// Associative key/value table: set, get, delete and clear over a row of slots.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+----------------------------------------
//   request | in  | i_valid / o_stall  | i_op, i_key, i_value
//   result  | out | o_valid / i_stall  | o_status, o_found, o_value_out,
//           |     |                    | o_entry_count
//
// Steps: an item walks the row of TABLE_DEPTH cells, one cell per cycle; the
// pending result is then registered and the table written, and the result is
// then loaded into the output register once that register is free.
// Reset: synchronous, active low; clears all valid marks and the count.
// Stalls: a finished result waits in the output register while the next item
// is accepted; only a result that cannot leave holds up the controller.
// ----------------------------------------------------------------------------
module associative_key_value_table_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [1:0]                i_op,
    input  wire logic [63:0]               i_key,
    input  wire logic [63:0]               i_value,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [1:0]                     o_status,
    output logic                           o_found,
    output logic [63:0]                    o_value_out,
    output logic [akv_pkg::CNT_W-1:0]      o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DONE   = 3'b100
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [akv_pkg::CNT_W-1:0] r_count;
    logic [akv_pkg::CNT_W-1:0] n_count;

    // pending result, captured when the search item leaves the row
    akv_pkg::t_status          r_pend_status;
    akv_pkg::t_status          n_pend_status;
    logic                      r_pend_found;
    logic                      n_pend_found;
    logic [akv_pkg::VAL_W-1:0] r_pend_value;
    logic [akv_pkg::VAL_W-1:0] n_pend_value;

    // output register
    logic                      r_out_valid;
    logic                      n_out_valid;
    akv_pkg::t_status          r_out_status;
    akv_pkg::t_status          n_out_status;
    logic                      r_out_found;
    logic                      n_out_found;
    logic [akv_pkg::VAL_W-1:0] r_out_value;
    logic [akv_pkg::VAL_W-1:0] n_out_value;
    logic [akv_pkg::CNT_W-1:0] r_out_count;
    logic [akv_pkg::CNT_W-1:0] n_out_count;

    logic                      w_accept;
    logic                      w_out_free;
    akv_pkg::t_token           w_tok [0:akv_pkg::TABLE_DEPTH];
    akv_pkg::t_token           w_end;
    akv_pkg::t_cell_ctl        w_ctl;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // Inject the trimmed request at the head of the row; cell 0 sees it at
    // the accepting edge.
    assign w_tok[0] = '{
        valid:     w_accept,
        op:        akv_pkg::t_op'(i_op),
        key:       akv_pkg::trim_key(i_key),
        value:     akv_pkg::trim_value(i_value),
        hit:       1'b0,
        hit_value: '0,
        free_seen: 1'b0,
        free_idx:  '0
    };

    genvar g;
    generate
        for (g = 0; g < akv_pkg::TABLE_DEPTH; g++) begin : g_cell
            akv_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (akv_pkg::IDX_W'(g)),
                .i_ctl   (w_ctl),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    assign w_end = w_tok[akv_pkg::TABLE_DEPTH];

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_pend_status = r_pend_status;
        n_pend_found  = r_pend_found;
        n_pend_value  = r_pend_value;
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_found   = r_out_found;
        n_out_value   = r_out_value;
        n_out_count   = r_out_count;

        w_ctl          = '0;
        w_ctl.fill_idx = w_end.free_idx;
        w_ctl.key      = w_end.key;
        w_ctl.value    = w_end.value;

        // drop the delivered result
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_end.valid) begin
                    n_state       = S_DONE;
                    n_pend_status = akv_pkg::ST_OK;
                    n_pend_found  = 1'b0;
                    n_pend_value  = '0;
                    case (w_end.op)
                        akv_pkg::OP_SET: begin
                            if (w_end.hit) begin
                                // value already rewritten in the hit cell
                                n_pend_found = 1'b1;
                            end else if (r_count >= akv_pkg::CNT_W'(akv_pkg::TABLE_DEPTH)
                                         || !w_end.free_seen) begin
                                n_pend_status = akv_pkg::ST_FULL;
                            end else begin
                                // fill the lowest free slot
                                w_ctl.fill = 1'b1;
                                n_count    = r_count + akv_pkg::CNT_W'(1);
                            end
                        end
                        akv_pkg::OP_GET: begin
                            if (w_end.hit) begin
                                n_pend_found = 1'b1;
                                n_pend_value = w_end.hit_value;
                            end else begin
                                n_pend_status = akv_pkg::ST_MISS;
                            end
                        end
                        akv_pkg::OP_DEL: begin
                            if (w_end.hit) begin
                                // slot already invalidated by the hit cell
                                n_pend_found = 1'b1;
                                if (r_count != '0) begin
                                    n_count = r_count - akv_pkg::CNT_W'(1);
                                end
                            end else begin
                                n_pend_status = akv_pkg::ST_MISS;
                            end
                        end
                        akv_pkg::OP_CLEAR: begin
                            w_ctl.clear = 1'b1;
                            n_count     = '0;
                        end
                        default: begin
                            n_pend_status = akv_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (w_out_free) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend_status;
                    n_out_found  = r_pend_found;
                    n_out_value  = r_pend_value;
                    n_out_count  = r_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_status <= n_pend_status;
        r_pend_found  <= n_pend_found;
        r_pend_value  <= n_pend_value;
        r_out_status  <= n_out_status;
        r_out_found   <= n_out_found;
        r_out_value   <= n_out_value;
        r_out_count   <= n_out_count;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found       = r_out_found;
    assign o_value_out   = r_out_value;
    assign o_entry_count = r_out_count;

endmodule
`default_nettype wire
